@@ hw/rtl/base64_stream_decoder_defines.svh @@
// ----------------------------------------------------------------------------
// base64_stream_decoder_defines: assertion macros for the decoder
// Each macro states one implication checked at the rising edge of clk.
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_DECODER_DEFINES_SVH
`define BASE64_STREAM_DECODER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define B64D_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		(ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define B64D_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		(ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/b64d_pkg.sv @@
// ----------------------------------------------------------------------------
// b64d_pkg: types and functions of the base64 stream decoder
// Character mapping, group decoding and the result bundle passed to the
// output buffer.
// ----------------------------------------------------------------------------
package b64d_pkg;

	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;
	localparam logic [7:0] CH_DIGIT_0 = 8'h30;
	localparam logic [7:0] CH_DIGIT_9 = 8'h39;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_SLASH   = 8'h2F;

	localparam logic [7:0] OFS_UPPER = 8'd65;  // 'A' maps to 0
	localparam logic [7:0] OFS_LOWER = 8'd71;  // 'a' maps to 26
	localparam logic [7:0] OFS_DIGIT = 8'd4;   // '0' maps to 52, added
	localparam logic [5:0] VAL_PLUS  = 6'd62;
	localparam logic [5:0] VAL_SLASH = 6'd63;

	localparam int unsigned GROUP_BYTES = 3;

	typedef struct packed {
		logic       ok;
		logic [5:0] val;
	} b64d_sextet_t;

	// Up to three results produced by one item; data[0] goes out first.
	typedef struct packed {
		logic [GROUP_BYTES-1:0][7:0] data;
		logic [1:0]                  num;
		logic                        marker;
		logic                        eot;
	} b64d_bundle_t;

	function automatic b64d_sextet_t b64d_map(input logic [7:0] ch);
		b64d_sextet_t r;
		logic [7:0]   t;
		r.ok  = 1'b1;
		r.val = 6'd0;
		t     = 8'd0;
		if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
			t     = ch - OFS_UPPER;
			r.val = t[5:0];
		end else if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
			t     = ch - OFS_LOWER;
			r.val = t[5:0];
		end else if (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9) begin
			t     = ch + OFS_DIGIT;
			r.val = t[5:0];
		end else if (ch == CH_PLUS) begin
			r.val = VAL_PLUS;
		end else if (ch == CH_SLASH) begin
			r.val = VAL_SLASH;
		end else begin
			r.ok = 1'b0;
		end
		return r;
	endfunction

	function automatic logic [GROUP_BYTES-1:0][7:0] b64d_decode(
		input logic [5:0] a,
		input logic [5:0] b,
		input logic [5:0] c,
		input logic [5:0] d
	);
		logic [GROUP_BYTES-1:0][7:0] r;
		r[0] = {a, b[5:4]};
		r[1] = {b[3:0], c[5:2]};
		r[2] = {c[1:0], d};
		return r;
	endfunction

endpackage

@@ hw/rtl/b64d_char_if.sv @@
// ----------------------------------------------------------------------------
// b64d_char_if: character channel of the base64 stream decoder
// One item is one ASCII character with a flag on the last one of the text.
// ----------------------------------------------------------------------------
interface b64d_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_char;
	logic       final_char;

	modport source (output valid, output text_char, output final_char, input ready);
	modport sink (input valid, input text_char, input final_char, output ready);
endinterface

@@ hw/rtl/b64d_byte_if.sv @@
// ----------------------------------------------------------------------------
// b64d_byte_if: result channel of the base64 stream decoder
// One item is a decoded byte or an end-only marker.
// ----------------------------------------------------------------------------
interface b64d_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_valid;
	logic       end_of_text;

	modport source (output valid, output data_byte, output byte_valid, output end_of_text,
		input ready);
	modport sink (input valid, input data_byte, input byte_valid, input end_of_text,
		output ready);
endinterface

@@ hw/rtl/base64_stream_decoder.sv @@
// ----------------------------------------------------------------------------
// base64_stream_decoder: one character in per cycle while the output buffer can take
// it, decoded bytes out. The first result of an accepted character is presented in the
// cycle after it is accepted. Results leave one per cycle while the result port is
// ready; the next character is taken as the last result of the item leaves.
// Reset clears the group count and the stop flag and empties the result register.
// ----------------------------------------------------------------------------
`include "base64_stream_decoder_defines.svh"

module base64_stream_decoder
	import b64d_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	b64d_char_if.sink   text,
	b64d_byte_if.source result
);

	logic [2:0][5:0] store_q;
	logic [1:0]      group_count_q;
	logic            stopped_q;

	logic [2:0][5:0] store_n;
	logic [1:0]      count_n;
	logic            stopped_n;
	logic            complete;
	logic            accept;
	logic            can_load;
	b64d_sextet_t    sx;
	b64d_bundle_t    bundle;

	assign text.ready = can_load;
	assign accept     = text.valid && text.ready;

	always_comb begin
		sx        = b64d_map(text.text_char);
		store_n   = store_q;
		count_n   = group_count_q;
		stopped_n = stopped_q;
		complete  = 1'b0;
		if (!stopped_q) begin
			if (sx.ok) begin
				if (group_count_q == 2'd3) begin
					complete = 1'b1;
					count_n  = 2'd0;
				end else begin
					store_n[group_count_q] = sx.val;
					count_n                = group_count_q + 2'd1;
				end
			end else begin
				stopped_n = 1'b1;
			end
		end

		// A completed group uses the held values and the new one; a flush
		// uses the held values and emits only bytes they fully define.
		bundle.data   = b64d_decode(store_n[0], store_n[1], store_n[2], sx.val);
		bundle.num    = complete ? 2'd3 : 2'd0;
		bundle.marker = 1'b0;
		bundle.eot    = text.final_char;
		if (text.final_char) begin
			if (!complete) begin
				if (count_n >= 2'd2) begin
					bundle.num = count_n - 2'd1;
				end else begin
					bundle.num    = 2'd1;
					bundle.marker = 1'b1;
				end
			end
			count_n   = 2'd0;
			stopped_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_count_q <= 2'd0;
			stopped_q     <= 1'b0;
		end else if (accept) begin
			group_count_q <= count_n;
			stopped_q     <= stopped_n;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			store_q <= store_n;
		end
	end

	b64d_outbuf u_outbuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (accept),
		.bundle   (bundle),
		.can_load (can_load),
		.result   (result)
	);

	`B64D_ASSERT_NEXT(a_final_restarts, accept && text.final_char,
		group_count_q == 2'd0 && !stopped_q, "final character did not restart the text")
	`B64D_ASSERT_SAME(a_marker_ends, result.valid && !result.byte_valid,
		result.end_of_text, "end-only marker without end of text")
	`B64D_ASSERT_NEXT(a_results_follow, accept && bundle.num != 2'd0,
		result.valid, "results of an accepted item not presented")

endmodule

@@ hw/rtl/b64d_outbuf.sv @@
// ----------------------------------------------------------------------------
// b64d_outbuf: result register of the base64 stream decoder
// Holds the up to three results of one item and hands them out one per cycle
// while ready is high; a new bundle can load in the cycle the last one leaves.
// ----------------------------------------------------------------------------
module b64d_outbuf
	import b64d_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  b64d_bundle_t  bundle,
	output logic          can_load,
	b64d_byte_if.source   result
);

	logic [GROUP_BYTES-1:0][7:0] data_q;
	logic [1:0]                  num_q;
	logic [1:0]                  idx_q;
	logic                        marker_q;
	logic                        eot_q;
	logic                        at_last;
	logic                        pop;

	assign at_last  = (idx_q == (num_q - 2'd1));
	assign pop      = result.valid && result.ready;
	assign can_load = (num_q == 2'd0) || (at_last && result.ready);

	assign result.valid       = (num_q != 2'd0);
	assign result.data_byte   = marker_q ? 8'd0 : data_q[idx_q];
	assign result.byte_valid  = !marker_q;
	assign result.end_of_text = eot_q && at_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q <= 2'd0;
			idx_q <= 2'd0;
		end else if (load) begin
			num_q <= bundle.num;
			idx_q <= 2'd0;
		end else if (pop) begin
			if (at_last) begin
				num_q <= 2'd0;
				idx_q <= 2'd0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q   <= bundle.data;
			marker_q <= bundle.marker;
			eot_q    <= bundle.eot;
		end
	end

endmodule
